// ===== hw/rtl/ppda_pkg.sv =====
// ----------------------------------------------------------------------------
// ppda_pkg: shared types and constants
// Word formats, register indexes and the arctangent table for the periodic
// pair distance and angle block.
// ----------------------------------------------------------------------------
package ppda_pkg;

  localparam int COORD_W     = 32;
  localparam int LEN_W       = 31;
  localparam int MAG_W       = 32;
  localparam int ROOT_W      = 33;
  localparam int SEP_W       = 33;
  localparam int ANGLE_W     = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int NORM_W      = 40;
  localparam int NORM_STEPS  = 6;
  localparam int ROT_W       = 44;
  localparam int ACC_W       = 34;
  localparam int TABLE_SIZE  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEN_Z = 2'd2;

  localparam logic [LEN_W-1:0] BOX_LEN_RESET = 31'd65536;
  localparam logic [ACC_W-1:0] HALF_PI_Q30   = 34'd1686629713;

  localparam logic [30:0] ATAN_Q30 [TABLE_SIZE] = '{
    31'd843314857, 31'd497837830, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

  typedef struct packed {
    logic [LEN_W-1:0] x;
    logic [LEN_W-1:0] y;
    logic [LEN_W-1:0] z;
  } box_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic             coincident;
  } pair_t;

endpackage

// ===== hw/rtl/ppda_if.sv =====
// ----------------------------------------------------------------------------
// ppda_if: stream channels
// Valid/ready channels for particle pair words and result words.
// ----------------------------------------------------------------------------
interface ppda_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ppda_pkg::COORD_W-1:0]  a_x;
  logic signed [ppda_pkg::COORD_W-1:0]  a_y;
  logic signed [ppda_pkg::COORD_W-1:0]  a_z;
  logic signed [ppda_pkg::COORD_W-1:0]  b_x;
  logic signed [ppda_pkg::COORD_W-1:0]  b_y;
  logic signed [ppda_pkg::COORD_W-1:0]  b_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface ppda_out_if;
  logic                           valid;
  logic                           ready;
  logic [ppda_pkg::SEP_W-1:0]     separation;
  logic [ppda_pkg::ANGLE_W-1:0]   polar_angle;
  logic                           coincident;
  modport source (output valid, separation, polar_angle, coincident, input ready);
  modport sink (input valid, separation, polar_angle, coincident, output ready);
endinterface

// ===== hw/rtl/periodic_pair_distance_angle.sv =====
// Throughput: one pair word per cycle while the output is not stalled, set by the
// bit-per-stage square root pipelines and the one-iteration-per-stage CORDIC
// pipeline.
// A four-word queue separates the minimum-image front end from the back end.
// Reset clears all valid flags and queue pointers and sets every box length to 1.0.
// ----------------------------------------------------------------------------
// periodic_pair_distance_angle: minimum-image pair distance and polar angle
// Top level: box length registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module periodic_pair_distance_angle #(
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 18
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ppda_in_if.sink                          in_ch,
  ppda_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ppda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppda_pkg::LEN_W-1:0]       cfg_wdata
);

  ppda_pkg::box_t  box_r;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  ppda_pkg::pair_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.x <= ppda_pkg::BOX_LEN_RESET;
      box_r.y <= ppda_pkg::BOX_LEN_RESET;
      box_r.z <= ppda_pkg::BOX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppda_pkg::REG_BOX_LEN_X: box_r.x <= cfg_wdata;
        ppda_pkg::REG_BOX_LEN_Y: box_r.y <= cfg_wdata;
        ppda_pkg::REG_BOX_LEN_Z: box_r.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .box        (box_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ppda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ppda_back #(
    .FRAC_BITS        (FRAC_BITS),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.coincident |->
      out_ch.separation == '0 && out_ch.polar_angle == '0)
    else $error("coincident word with non-zero result");
`endif

endmodule

// ===== hw/rtl/ppda_front.sv =====
// ----------------------------------------------------------------------------
// ppda_front: minimum-image front end
// Takes pair words, forms the per-axis differences, applies the periodic
// shift and flags coincident pairs. Three register stages.
// ----------------------------------------------------------------------------
module ppda_front (
  input  logic            clk,
  input  logic            rst_n,
  ppda_in_if.sink         in_ch,
  input  ppda_pkg::box_t  box,
  output logic            push_valid,
  input  logic            push_ready,
  output ppda_pkg::pair_t push_data
);

  logic adv;
  logic v1_r, v2_r, v3_r;

  logic signed [32:0] a_s [3];
  logic signed [32:0] b_s [3];
  logic [ppda_pkg::LEN_W-1:0] len [3];

  logic signed [32:0] d_r [3];
  logic signed [32:0] e_r [3];
  logic signed [32:0] d_nxt [3];
  logic signed [32:0] e_nxt [3];

  logic [33:0] ad_r [3];
  logic [33:0] adl_r [3];
  logic [33:0] adr_r [3];
  logic [33:0] ad_nxt [3];
  logic [33:0] adl_nxt [3];
  logic [33:0] adr_nxt [3];

  logic [ppda_pkg::MAG_W-1:0] mag_r [3];
  logic [ppda_pkg::MAG_W-1:0] mag_nxt [3];

  logic signed [33:0] dw [3];
  logic signed [33:0] ew [3];
  logic signed [33:0] lw [3];
  logic signed [33:0] dl [3];
  logic signed [33:0] ndl [3];
  logic signed [33:0] dr [3];
  logic signed [33:0] ndr [3];
  logic lt_l [3];
  logic lt_r [3];

  assign adv         = !v3_r || push_ready;
  assign in_ch.ready = adv;

  assign a_s[0] = 33'(in_ch.a_x);
  assign a_s[1] = 33'(in_ch.a_y);
  assign a_s[2] = 33'(in_ch.a_z);
  assign b_s[0] = 33'(in_ch.b_x);
  assign b_s[1] = 33'(in_ch.b_y);
  assign b_s[2] = 33'(in_ch.b_z);
  assign len[0] = box.x;
  assign len[1] = box.y;
  assign len[2] = box.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = a_s[k] - b_s[k];
      e_nxt[k] = b_s[k] - a_s[k];

      dw[k]  = 34'(d_r[k]);
      ew[k]  = 34'(e_r[k]);
      lw[k]  = $signed({3'b000, len[k]});
      dl[k]  = dw[k] - lw[k];
      ndl[k] = ew[k] + lw[k];
      dr[k]  = dw[k] + lw[k];
      ndr[k] = ew[k] - lw[k];
      ad_nxt[k]  = dw[k][33] ? ew[k] : dw[k];
      adl_nxt[k] = dl[k][33] ? ndl[k] : dl[k];
      adr_nxt[k] = dr[k][33] ? ndr[k] : dr[k];

      lt_l[k] = adl_r[k] < ad_r[k];
      lt_r[k] = adr_r[k] < ad_r[k];
      priority if (lt_l[k] && !lt_r[k]) begin
        mag_nxt[k] = adl_r[k][ppda_pkg::MAG_W-1:0];
      end else if (lt_r[k] && !lt_l[k]) begin
        mag_nxt[k] = adr_r[k][ppda_pkg::MAG_W-1:0];
      end else begin
        mag_nxt[k] = ad_r[k][ppda_pkg::MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= d_nxt;
      e_r     <= e_nxt;
      ad_r    <= ad_nxt;
      adl_r   <= adl_nxt;
      adr_r   <= adr_nxt;
      mag_r   <= mag_nxt;
    end
  end

  assign push_valid           = v3_r;
  assign push_data.mag_x      = mag_r[0];
  assign push_data.mag_y      = mag_r[1];
  assign push_data.mag_z      = mag_r[2];
  assign push_data.coincident = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);

endmodule

// ===== hw/rtl/ppda_queue.sv =====
// ----------------------------------------------------------------------------
// ppda_queue: front-to-back queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ppda_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ppda_pkg::pair_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ppda_pkg::pair_t pop_data
);

  localparam int DEPTH = ppda_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppda_pkg::pair_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push_fire && !pop_fire |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not follow a push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && !push_fire |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("queue count did not follow a pop");
`endif

endmodule

// ===== hw/rtl/ppda_sqrt.sv =====
// ----------------------------------------------------------------------------
// ppda_sqrt: pipelined integer square root
// Floor square root, one result bit per register stage, stalled by en.
// ----------------------------------------------------------------------------
module ppda_sqrt #(
  parameter int ROOT_W = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  logic [2*ROOT_W-1:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [2*ROOT_W-1:0] rem_in;
    logic [2*ROOT_W-1:0] term;
    logic [ROOT_W-1:0]   root_in;

    if (s == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    assign term = ({{ROOT_W{1'b0}}, root_in} << (B + 1)) | ((2*ROOT_W)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= term) begin
          rem_r[s]  <= rem_in - term;
          root_r[s] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_r[s]  <= rem_in;
          root_r[s] <= root_in;
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// ===== hw/rtl/ppda_back.sv =====
// ----------------------------------------------------------------------------
// ppda_back: distance and angle back end
// Squares and sums the corrected differences, takes both square roots,
// normalises the vector and runs the CORDIC angle pipeline.
// ----------------------------------------------------------------------------
module ppda_back #(
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 18
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  ppda_pkg::pair_t pop_data,
  ppda_out_if.source      out_ch
);

  localparam int RW = ppda_pkg::ROOT_W;
  localparam int NS = ppda_pkg::NORM_STEPS;
  localparam int NW = ppda_pkg::NORM_W;
  localparam int XW = ppda_pkg::ROT_W;
  localparam int ZW = ppda_pkg::ACC_W;
  localparam int NI = (ANGLE_ITERATIONS > ppda_pkg::TABLE_SIZE) ?
                      ppda_pkg::TABLE_SIZE : ANGLE_ITERATIONS;
  localparam int T  = 3 + RW + NS + NI + 1;

  logic         adv;
  logic [T-1:0] valid_r;

  logic [63:0] sx_r, sy_r, sz_r, sz1_r;
  logic [64:0] ph_r, ph2_r;
  logic [65:0] th_r;
  logic [ppda_pkg::MAG_W-1:0] az0_r, az1_r, az2_r;
  logic c0_r, c1_r, c2_r;

  logic [ppda_pkg::MAG_W-1:0] az_d_r [RW];
  logic                       c_d_r  [RW];
  logic [RW-1:0] sep_root, rp_root;

  logic [NW-1:0] nx_r [NS];
  logic [NW-1:0] ny_r [NS];
  logic [RW-1:0] sep_n_r [NS];
  logic          c_n_r [NS];

  logic signed [XW-1:0] x_r [NI];
  logic signed [XW-1:0] y_r [NI];
  logic signed [ZW-1:0] z_r [NI];
  logic [RW-1:0]        sep_c_r [NI];
  logic                 c_c_r [NI];

  logic [ppda_pkg::SEP_W-1:0]   sep_o_r;
  logic [ppda_pkg::ANGLE_W-1:0] ang_o_r;
  logic                         coin_o_r;
  logic [ZW-1:0] zc, rnd;
  logic [ppda_pkg::ANGLE_W-1:0] ang_nxt;

  assign adv       = !valid_r[T-1] || out_ch.ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[T-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r  <= 64'(pop_data.mag_x) * 64'(pop_data.mag_x);
      sy_r  <= 64'(pop_data.mag_y) * 64'(pop_data.mag_y);
      sz_r  <= 64'(pop_data.mag_z) * 64'(pop_data.mag_z);
      az0_r <= pop_data.mag_z;
      c0_r  <= pop_data.coincident;
      ph_r  <= 65'(sx_r) + 65'(sy_r);
      sz1_r <= sz_r;
      az1_r <= az0_r;
      c1_r  <= c0_r;
      th_r  <= 66'(ph_r) + 66'(sz1_r);
      ph2_r <= ph_r;
      az2_r <= az1_r;
      c2_r  <= c1_r;
    end
  end

  ppda_sqrt #(.ROOT_W(RW)) u_sqrt_sep (
    .clk  (clk),
    .en   (adv),
    .rad  (th_r),
    .root (sep_root)
  );

  ppda_sqrt #(.ROOT_W(RW)) u_sqrt_plane (
    .clk  (clk),
    .en   (adv),
    .rad  ({1'b0, ph2_r}),
    .root (rp_root)
  );

  for (genvar s = 0; s < RW; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        az_d_r[s] <= (s == 0) ? az2_r : az_d_r[(s == 0) ? 0 : s-1];
        c_d_r[s]  <= (s == 0) ? c2_r  : c_d_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int K = 1 << (NS - 1 - j);
    logic [NW-1:0] x_in, y_in;
    logic [RW-1:0] sep_in;
    logic          c_in;

    if (j == 0) begin : g_first
      assign x_in   = NW'(az_d_r[RW-1]);
      assign y_in   = NW'(rp_root);
      assign sep_in = sep_root;
      assign c_in   = c_d_r[RW-1];
    end else begin : g_next
      assign x_in   = nx_r[j-1];
      assign y_in   = ny_r[j-1];
      assign sep_in = sep_n_r[j-1];
      assign c_in   = c_n_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (((x_in | y_in) >> (NW - K)) == '0) begin
          nx_r[j] <= x_in << K;
          ny_r[j] <= y_in << K;
        end else begin
          nx_r[j] <= x_in;
          ny_r[j] <= y_in;
        end
        sep_n_r[j] <= sep_in;
        c_n_r[j]   <= c_in;
      end
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_rot
    logic signed [XW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0] z_in, at;
    logic [RW-1:0]        sep_in;
    logic                 c_in;

    if (i == 0) begin : g_first
      assign x_in   = $signed(XW'(nx_r[NS-1]));
      assign y_in   = $signed(XW'(ny_r[NS-1]));
      assign z_in   = '0;
      assign sep_in = sep_n_r[NS-1];
      assign c_in   = c_n_r[NS-1];
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign sep_in = sep_c_r[i-1];
      assign c_in   = c_c_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = $signed({3'b000, ppda_pkg::ATAN_Q30[i]});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_in[XW-1]) begin
          x_r[i] <= x_in + ys;
          y_r[i] <= y_in - xs;
          z_r[i] <= z_in + at;
        end else begin
          x_r[i] <= x_in - ys;
          y_r[i] <= y_in + xs;
          z_r[i] <= z_in - at;
        end
        sep_c_r[i] <= sep_in;
        c_c_r[i]   <= c_in;
      end
    end
  end

  always_comb begin
    priority if (z_r[NI-1][ZW-1]) begin
      zc = '0;
    end else if ($unsigned(z_r[NI-1]) > ppda_pkg::HALF_PI_Q30) begin
      zc = ppda_pkg::HALF_PI_Q30;
    end else begin
      zc = $unsigned(z_r[NI-1]);
    end
    rnd     = (zc + (ZW'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    ang_nxt = rnd[ppda_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coin_o_r <= c_c_r[NI-1];
      sep_o_r  <= c_c_r[NI-1] ? '0 : sep_c_r[NI-1];
      ang_o_r  <= c_c_r[NI-1] ? '0 : ang_nxt;
    end
  end

  assign out_ch.valid       = valid_r[T-1];
  assign out_ch.separation  = sep_o_r;
  assign out_ch.polar_angle = ang_o_r;
  assign out_ch.coincident  = coin_o_r;

endmodule

// ===== tb/tb_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chan_if: testbench view of the stream channels
// The channel interfaces themselves come from the RTL; this file only keeps
// the agreed layout of the testbench and holds the pair word type.
// ----------------------------------------------------------------------------
package tb_pair_pkg;
  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } pair_word_t;
endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for periodic_pair_distance_angle
// Drives particle pair words under random idling and back-pressure through
// several box length settings, predicts the minimum-image distance and polar
// angle of each word and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int LAT = 65;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ppda_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppda_pkg::LEN_W-1:0] cfg_wdata = '0;

  ppda_in_if in_ch ();
  ppda_out_if out_ch ();

  periodic_pair_distance_angle DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [32:0] sep;
    logic [16:0] ang;
    logic        coin;
  } result_t;

  tb_pair_pkg::pair_word_t pending_words[$];
  result_t    expected_results[$];
  logic [30:0] len_x = 31'd65536, len_y = 31'd65536, len_z = 31'd65536;
  int errors = 0;
  bit calm = 0;
  bit hold_long = 0;
  int send_gap = 0, recv_gap = 0, hold_cnt = 0;

  longint unsigned atan_tab[32] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1, 0
  };

  function automatic longint wrap_axis(longint a, longint b, logic [30:0] l);
    longint d, ll, ad, adl, adr;
    d = a - b;
    ll = longint'(l);
    ad = d < 0 ? -d : d;
    adl = (d - ll) < 0 ? -(d - ll) : d - ll;
    adr = (d + ll) < 0 ? -(d + ll) : d + ll;
    if (adl < ad && !(adr < ad)) return d - ll;
    if (adr < ad && !(adl < ad)) return d + ll;
    return d;
  endfunction

  function automatic logic [34:0] floor_root(logic [127:0] v);
    logic [34:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({93'd0, c} * {93'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [16:0] polar_from(longint z_abs, longint rp);
    longint x, y, acc, xs, ys;
    x = z_abs;
    y = rp;
    acc = 0;
    while ((x > y ? x : y) < (64'sd1 <<< 39)) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; acc += longint'(atan_tab[i]);
      end else begin
        x -= ys; y += xs; acc -= longint'(atan_tab[i]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 1686629713) acc = 1686629713;
    return 17'((acc + (64'sd1 <<< 13)) >>> 14);
  endfunction

  function automatic result_t distance_angle(tb_pair_pkg::pair_word_t w);
    result_t r;
    longint dx, dy, dz;
    logic [127:0] pl, tot;
    dx = wrap_axis(w.ax, w.bx, len_x);
    dy = wrap_axis(w.ay, w.by, len_y);
    dz = wrap_axis(w.az, w.bz, len_z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    pl = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    tot = pl + 128'(dz) * 128'(dz);
    if (tot == 0) begin
      r.sep = '0; r.ang = '0; r.coin = 1'b1;
    end else begin
      r.sep = 33'(floor_root(tot));
      r.ang = polar_from(dz, longint'(floor_root(pl)));
      r.coin = 1'b0;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(distance_angle(pending_words.pop_front()));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        if (in_ch.valid && in_ch.ready) in_ch.valid <= 1'b0;
      end else if (!(in_ch.valid && !in_ch.ready)) begin
        if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(1, 10);
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.a_x <= pending_words[0].ax;
          in_ch.a_y <= pending_words[0].ay;
          in_ch.a_z <= pending_words[0].az;
          in_ch.b_x <= pending_words[0].bx;
          in_ch.b_y <= pending_words[0].by;
          in_ch.b_z <= pending_words[0].bz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result sep=%0d ang=%0d coin=%0d", $time,
                   out_ch.separation, out_ch.polar_angle, out_ch.coincident);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.separation !== e.sep || out_ch.polar_angle !== e.ang ||
              out_ch.coincident !== e.coin) begin
            $display({"%0t: mismatch expected sep=%0d ang=%0d coin=%0d",
                      " actual sep=%0d ang=%0d coin=%0d"},
                     $time, e.sep, e.ang, e.coin, out_ch.separation,
                     out_ch.polar_angle, out_ch.coincident);
            errors++;
          end
        end
      end
      if (hold_long && hold_cnt < 200) begin
        hold_cnt <= hold_cnt + 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 8)) - 4;
      3: return $signed($urandom()) >>> $urandom_range(0, 31);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic queue_pair(logic signed [31:0] ax, ay, az, bx, by, bz);
    tb_pair_pkg::pair_word_t w;
    w.ax = ax; w.ay = ay; w.az = az; w.bx = bx; w.by = by; w.bz = bz;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_box(logic [ppda_pkg::CFG_IDX_W-1:0] idx,
                           logic [ppda_pkg::LEN_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == ppda_pkg::REG_BOX_LEN_X) len_x = v;
    else if (idx == ppda_pkg::REG_BOX_LEN_Y) len_y = v;
    else if (idx == ppda_pkg::REG_BOX_LEN_Z) len_z = v;
  endtask

  task automatic random_pairs(int n, bit near);
    logic signed [31:0] ax, ay, az;
    for (int i = 0; i < n; i++) begin
      ax = pick_coord(); ay = pick_coord(); az = pick_coord();
      if (near)
        queue_pair(ax, ay, az, ax + ($signed($urandom()) >>> 12),
                   ay + ($signed($urandom()) >>> 12), az + ($signed($urandom()) >>> 12));
      else
        queue_pair(ax, ay, az, pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    logic [30:0] lens[5];
    lens = '{31'd0, 31'h7FFFFFFF, 31'd65536, 31'd1, 31'd3000000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed words at reset lengths
    queue_pair(0, 0, 0, 0, 0, 0);
    queue_pair(5, -7, 9, 5, -7, 9);
    queue_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h80000000, 32'h80000000, 32'h80000000);
    queue_pair(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0);
    queue_pair(32768, 0, 0, 0, 0, 0);
    queue_pair(-32768, 32768, -32768, 0, 0, 0);
    queue_pair(32769, 0, 65536, 0, 0, 0);
    queue_pair(65536, 65536, 0, 0, 0, 0);
    queue_pair(0, 0, 40000, 0, 0, 0);
    queue_pair(100, 0, 0, 0, 0, 0);
    queue_pair(65536, 0, 0, 0, 0, 0);
    drain();
    write_box(ppda_pkg::REG_BOX_LEN_X, 31'd0);
    write_box(ppda_pkg::REG_BOX_LEN_Y, 31'h7FFFFFFF);
    write_box(ppda_pkg::REG_BOX_LEN_Z, 31'd200);
    write_box(2'd3, 31'd12345);
    queue_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 100, 32'h80000000, 32'h80000000, 0);
    queue_pair(0, 32'h3FFFFFFF, -100, 0, 32'hC0000000, 0);
    queue_pair(-5, 1, 99, 7, 0, 0);
    queue_pair(0, 0, 300, 0, 0, 0);
    queue_pair(0, 0, 0, 0, 0, 0);
    queue_pair(0, 0, 200, 0, 0, 0);
    // fill the block while the receiver holds off
    hold_long = 1'b1;
    random_pairs(150, 0);
    drain();
    hold_long = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      write_box(ppda_pkg::REG_BOX_LEN_X, lens[$urandom_range(0, 4)]);
      write_box(ppda_pkg::REG_BOX_LEN_Y, ph == 0 ? 31'h7FFFFFFF : 31'($urandom()));
      write_box(ppda_pkg::REG_BOX_LEN_Z, lens[$urandom_range(0, 4)]);
      if (ph == 5) calm = 1'b1;
      random_pairs(105, 1);
      random_pairs(105, 0);
      drain();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
